FILE: src/terrain_grid_mesh_generator_macros.svh
// Assertion macros shared by the terrain grid mesh generator RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef TERRAIN_GRID_MESH_GENERATOR_MACROS_SVH
`define TERRAIN_GRID_MESH_GENERATOR_MACROS_SVH

// Same-cycle implication, off during reset.
`define TGM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define TGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tgm_pkg.sv
// Package for the terrain grid mesh generator: constants, codes and types.
// No dependencies; used by every module of the block.
package tgm_pkg;

    localparam int MAX_GRID_SIDE    = 256;
    localparam int MAX_MAP_SIDE     = 256;
    localparam int TEX_REPEAT       = 3;
    localparam int UV_FRACTION_BITS = 16;

    localparam int CFG_W   = 9;
    localparam int COORD_W = 8;
    localparam int ADDR_W  = 16;
    localparam int STORE_DEPTH = MAX_MAP_SIDE * MAX_MAP_SIDE;
    localparam int TEX_INT_W = 10;                       // TEX_REPEAT * 255
    localparam int DIV_W   = TEX_INT_W + UV_FRACTION_BITS;
    localparam int QDEPTH  = 2;
    localparam int NB_COUNT = 7;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_VERTEX = 2'd1;
    localparam logic [1:0] OP_CELL   = 2'd2;

    localparam logic [2:0] CFG_GRID_X  = 3'd0;
    localparam logic [2:0] CFG_GRID_Z  = 3'd1;
    localparam logic [2:0] CFG_MAP_W   = 3'd2;
    localparam logic [2:0] CFG_MAP_H   = 3'd3;
    localparam logic [2:0] CFG_USE_MAP = 3'd4;

    typedef enum logic [2:0] {
        CLS_LOAD       = 3'd0,
        CLS_VERTEX     = 3'd1,
        CLS_CELL       = 3'd2,
        CLS_BAD_VERTEX = 3'd3,
        CLS_BAD_CELL   = 3'd4
    } cls_t;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [CFG_W-1:0] gx;
        logic [CFG_W-1:0] gz;
        logic [CFG_W-1:0] mw;
        logic [CFG_W-1:0] mh;
        logic             use_map;
    } cfg_t;

    typedef struct packed {
        cls_t               cls;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [7:0]         sample;
    } job_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         height_raw;
        logic signed [11:0] normal_x;
        logic [6:0]         normal_y;
        logic signed [11:0] normal_z;
        logic [17:0]        tex_u;
        logic [17:0]        tex_v;
        logic [15:0]        index_a;
        logic [15:0]        index_b;
        logic [15:0]        index_c;
        logic               last;
        logic               bad_coordinate;
    } result_t;

    // Neighbor order: center, north, east, south, south-east, west, north-west.
    function automatic logic [CFG_W-1:0] nb_dx(input logic [2:0] k);
        case (k)
            3'd2, 3'd4: nb_dx = 9'd1;
            3'd5, 3'd6: nb_dx = '1;
            default:    nb_dx = '0;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] nb_dz(input logic [2:0] k);
        case (k)
            3'd1, 3'd6: nb_dz = 9'd1;
            3'd3, 3'd4: nb_dz = '1;
            default:    nb_dz = '0;
        endcase
    endfunction

endpackage

FILE: src/tgm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tgm_pkg.
module tgm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tgm_pkg::DIV_W-1:0] dividend,
    input  logic [7:0]                divisor,
    output logic                      div_busy,
    output logic [tgm_pkg::DIV_W-1:0] quotient
);
    import tgm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [7:0]       rem_reg;
    logic [7:0]       dsr_reg;
    logic [8:0]       trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? 8'(trial - {1'b0, dsr_reg}) : trial[7:0];
        end
    end

    assign div_busy = cnt_reg != '0;
    assign quotient = quo_reg;
endmodule

FILE: src/tgm_front.sv
// Front end: classifies accepted items and queues them for the back end.
// Depends on tgm_pkg and the assertion macro header.
`include "terrain_grid_mesh_generator_macros.svh"
module tgm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tgm_pkg::cfg_t               cfg,
    input  logic                        start,
    input  logic [1:0]                  opcode,
    input  logic [tgm_pkg::COORD_W-1:0] col,
    input  logic [tgm_pkg::COORD_W-1:0] row,
    input  logic [7:0]                  sample_value,
    output logic                        busy,
    output logic                        job_valid,
    output tgm_pkg::job_t               job,
    input  logic                        job_take
);
    import tgm_pkg::*;

    job_t       q_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       accept;
    logic       push;
    logic       pop;
    job_t       cls_job;
    logic       keep;

    assign busy   = count_reg == 2'(QDEPTH);
    assign accept = start && !busy;

    // Classification; loads off the map and opcode 3 are dropped here.
    always_comb
    begin
        cls_job.col    = col;
        cls_job.row    = row;
        cls_job.sample = sample_value;
        cls_job.cls    = CLS_LOAD;
        keep           = 1'b0;
        case (opcode)
            OP_LOAD:
            begin
                keep = ({1'b0, col} < cfg.mw) && ({1'b0, row} < cfg.mh);
            end
            OP_VERTEX:
            begin
                keep = 1'b1;
                cls_job.cls = (({1'b0, col} < cfg.gx) && ({1'b0, row} < cfg.gz))
                              ? CLS_VERTEX : CLS_BAD_VERTEX;
            end
            OP_CELL:
            begin
                keep = 1'b1;
                cls_job.cls = (({1'b0, col} < 9'(cfg.gx - 1'b1))
                              && ({1'b0, row} < 9'(cfg.gz - 1'b1)))
                              ? CLS_CELL : CLS_BAD_CELL;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = accept && keep;
    assign pop  = job_take;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls_job;
        end
    end

    assign job_valid = count_reg != '0;
    assign job       = q_reg[rd_ptr_reg];

    `TGM_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= 2'(QDEPTH), "queue over depth")
    `TGM_ASSERT_IMP(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")
    `TGM_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 2'd1,
        "push lost")
endmodule

FILE: src/tgm_back.sv
// Back end: height store, vertex sequencer with shared divider, cell indices.
// Depends on tgm_pkg, tgm_div and the assertion macro header.
`include "terrain_grid_mesh_generator_macros.svh"
module tgm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  tgm_pkg::cfg_t    cfg,
    input  logic             job_valid,
    input  tgm_pkg::job_t    job,
    output logic             job_take,
    output logic             res_valid,
    output tgm_pkg::result_t res
);
    import tgm_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_LOAD_ADDR = 14'b00000000000010,
        S_LOAD_WR   = 14'b00000000000100,
        S_DIV_GO    = 14'b00000000001000,
        S_DIV_WAIT  = 14'b00000000010000,
        S_NB_MUL    = 14'b00000000100000,
        S_NB_ADDR   = 14'b00000001000000,
        S_NB_RD     = 14'b00000010000000,
        S_NB_CAP    = 14'b00000100000000,
        S_V_EMIT    = 14'b00001000000000,
        S_CELL_MUL  = 14'b00010000000000,
        S_TRI0      = 14'b00100000000000,
        S_TRI1      = 14'b01000000000000,
        S_BAD       = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    job_t   job_reg;
    logic [1:0] div_idx_reg;
    logic [2:0] nb_k_reg;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0] mx_reg, my_reg;
    logic [CFG_W-1:0] step_x_reg, step_z_reg;
    logic [17:0] u_reg, v_reg;
    logic [16:0] cell_v_reg;
    logic [7:0] h_reg [NB_COUNT];
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;

    logic             div_start, div_busy;
    logic [DIV_W-1:0] div_dividend, div_quotient;
    logic [7:0]       div_divisor;
    logic [7:0]       gx_m1, gz_m1;
    logic [TEX_INT_W-1:0] tex_u_int, tex_v_int;

    logic [CFG_W-1:0] xi, zi;
    logic [17:0] mx_full, mz_full;
    logic [7:0]  a_lo, a_hi;
    logic [16:0] addr_full;

    assign gx_m1 = 8'(cfg.gx - 1'b1);
    assign gz_m1 = 8'(cfg.gz - 1'b1);
    assign tex_u_int = TEX_INT_W'(TEX_REPEAT * job_reg.col);
    assign tex_v_int = TEX_INT_W'(TEX_REPEAT * 8'(gz_m1 - job_reg.row));

    assign job_take  = (state_reg == S_IDLE) && job_valid;
    assign div_start = state_reg == S_DIV_GO;

    always_comb
    begin
        case (div_idx_reg)
            2'd0:    begin div_dividend = DIV_W'(cfg.mw); div_divisor = gx_m1; end
            2'd1:    begin div_dividend = DIV_W'(cfg.mh); div_divisor = gz_m1; end
            2'd2:    begin div_dividend = {tex_u_int, UV_FRACTION_BITS'(0)};
                           div_divisor = gx_m1; end
            default: begin div_dividend = {tex_v_int, UV_FRACTION_BITS'(0)};
                           div_divisor = gz_m1; end
        endcase
    end

    tgm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .div_busy (div_busy),
        .quotient (div_quotient)
    );

    // Map position of neighbor vertex, clamped into the map.
    assign xi      = 9'({1'b0, job_reg.col} + nb_dx(nb_k_reg));
    assign zi      = 9'({1'b0, job_reg.row} + nb_dz(nb_k_reg));
    assign mx_full = step_x_reg * xi;
    assign mz_full = step_z_reg * zi;

    // Shared store address: row * map_width + col.
    assign a_hi      = (state_reg == S_LOAD_ADDR) ? job_reg.row : my_reg;
    assign a_lo      = (state_reg == S_LOAD_ADDR) ? job_reg.col : mx_reg;
    assign addr_full = 17'(a_hi * cfg.mw) + 17'(a_lo);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    unique case (job.cls)
                        CLS_LOAD:   state_next = S_LOAD_ADDR;
                        CLS_VERTEX: state_next = S_DIV_GO;
                        CLS_CELL:   state_next = S_CELL_MUL;
                        default:    state_next = S_BAD;
                    endcase
                end
            end
            S_LOAD_ADDR: state_next = S_LOAD_WR;
            S_DIV_GO:    state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    if (div_idx_reg == 2'd1)
                    begin
                        state_next = S_NB_MUL;
                    end
                    else if (div_idx_reg == 2'd3)
                    begin
                        state_next = S_V_EMIT;
                    end
                    else
                    begin
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_NB_MUL:  state_next = S_NB_ADDR;
            S_NB_ADDR: state_next = S_NB_RD;
            S_NB_RD:   state_next = S_NB_CAP;
            S_NB_CAP:  state_next = (nb_k_reg == 3'(NB_COUNT - 1)) ? S_DIV_GO : S_NB_MUL;
            S_CELL_MUL: state_next = S_TRI0;
            S_TRI0:     state_next = S_TRI1;
            default:    state_next = S_IDLE;
        endcase
    end

    // Face presence around the vertex.
    logic ex, wx, nz, sz, f1, f2, f4, f5;
    logic [2:0] face_cnt;
    logic signed [11:0] hc, hn, he, hs, hse, hw, hnw, nx_sum, nz_sum;

    assign ex = {1'b0, job_reg.col} < 9'(cfg.gx - 1'b1);
    assign wx = job_reg.col != '0;
    assign nz = {1'b0, job_reg.row} < 9'(cfg.gz - 1'b1);
    assign sz = job_reg.row != '0;
    assign f1 = ex && nz;
    assign f2 = ex && sz;
    assign f4 = wx && sz;
    assign f5 = wx && nz;
    assign face_cnt = 3'(f1) + {f2, 1'b0} + 3'(f4) + {f5, 1'b0};

    assign hc  = $signed({4'b0, h_reg[0]});
    assign hn  = $signed({4'b0, h_reg[1]});
    assign he  = $signed({4'b0, h_reg[2]});
    assign hs  = $signed({4'b0, h_reg[3]});
    assign hse = $signed({4'b0, h_reg[4]});
    assign hw  = $signed({4'b0, h_reg[5]});
    assign hnw = $signed({4'b0, h_reg[6]});

    always_comb
    begin
        nx_sum = '0;
        nz_sum = '0;
        if (f1)
        begin
            nx_sum = nx_sum + (hc - he);
            nz_sum = nz_sum + (hc - hn);
        end
        if (f2)
        begin
            nx_sum = nx_sum + (hc - he) + (hs - hse);
            nz_sum = nz_sum + (hse - he) + (hs - hc);
        end
        if (f4)
        begin
            nx_sum = nx_sum + (hw - hc);
            nz_sum = nz_sum + (hs - hc);
        end
        if (f5)
        begin
            nx_sum = nx_sum + (hnw - hn) + (hw - hc);
            nz_sum = nz_sum + (hc - hn) + (hw - hnw);
        end
    end

    always_comb
    begin
        res_next       = '0;
        res_valid_next = 1'b0;
        case (state_reg)
            S_BAD:
            begin
                res_valid_next         = 1'b1;
                res_next.kind          = job_reg.cls == CLS_BAD_CELL;
                res_next.last          = 1'b1;
                res_next.bad_coordinate = 1'b1;
            end
            S_V_EMIT:
            begin
                res_valid_next      = 1'b1;
                res_next.height_raw = h_reg[0];
                res_next.normal_x   = nx_sum;
                res_next.normal_y   = 7'({face_cnt, 4'b0} - face_cnt);
                res_next.normal_z   = nz_sum;
                res_next.tex_u      = u_reg;
                res_next.tex_v      = 18'(div_quotient);
                res_next.last       = 1'b1;
            end
            S_TRI0:
            begin
                res_valid_next   = 1'b1;
                res_next.kind    = 1'b1;
                res_next.index_a = 16'(cell_v_reg + cfg.gx);
                res_next.index_b = 16'(cell_v_reg + cfg.gx + 1'b1);
                res_next.index_c = 16'(cell_v_reg + 1'b1);
            end
            S_TRI1:
            begin
                res_valid_next   = 1'b1;
                res_next.kind    = 1'b1;
                res_next.index_a = 16'(cell_v_reg + cfg.gx);
                res_next.index_b = 16'(cell_v_reg + 1'b1);
                res_next.index_c = 16'(cell_v_reg);
                res_next.last    = 1'b1;
            end
            default: res_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_idx_reg   <= '0;
            nb_k_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (job_take)
            begin
                div_idx_reg <= '0;
                nb_k_reg    <= '0;
            end
            else
            begin
                if ((state_reg == S_DIV_WAIT) && !div_busy)
                begin
                    div_idx_reg <= div_idx_reg + 1'b1;
                end
                if (state_reg == S_NB_CAP)
                begin
                    nb_k_reg <= nb_k_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (job_take)
        begin
            job_reg <= job;
        end
        if ((state_reg == S_DIV_WAIT) && !div_busy)
        begin
            case (div_idx_reg)
                2'd0:    step_x_reg <= div_quotient[CFG_W-1:0];
                2'd1:    step_z_reg <= div_quotient[CFG_W-1:0];
                2'd2:    u_reg      <= div_quotient[17:0];
                default: v_reg      <= div_quotient[17:0];
            endcase
        end
        if (state_reg == S_NB_MUL)
        begin
            mx_reg <= (mx_full > 18'(cfg.mw - 1'b1)) ? 8'(cfg.mw - 1'b1) : mx_full[7:0];
            my_reg <= (mz_full > 18'(cfg.mh - 1'b1)) ? 8'(cfg.mh - 1'b1) : mz_full[7:0];
        end
        if ((state_reg == S_NB_ADDR) || (state_reg == S_LOAD_ADDR))
        begin
            addr_reg <= addr_full[ADDR_W-1:0];
        end
        if (state_reg == S_NB_CAP)
        begin
            h_reg[nb_k_reg] <= cfg.use_map ? rd_data_reg : 8'd0;
        end
        if (state_reg == S_CELL_MUL)
        begin
            cell_v_reg <= 17'(job_reg.row * cfg.gx) + 17'(job_reg.col);
        end
    end

    // Height store: one port, registered read.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD_WR)
        begin
            mem[addr_reg] <= job_reg.sample;
        end
        rd_data_reg <= mem[addr_reg];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `TGM_ASSERT_IMP(a_take_idle, job_take, state_reg == S_IDLE, "take while busy")
    `TGM_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider restarted while busy")
    `TGM_ASSERT_NEXT(a_tri_pair, res_valid_reg && res_reg.kind && !res_reg.last,
        res_valid_reg && res_reg.kind && res_reg.last, "second triangle missing")
    `TGM_ASSERT_NEXT(a_v_order, (state_reg == S_V_EMIT), v_reg == $past(v_reg),
        "tex v overwritten at emit")
endmodule

FILE: src/terrain_grid_mesh_generator.sv
// Top level of the terrain grid mesh generator: config registers, front, back.
// Depends on tgm_pkg, tgm_front, tgm_back (and tgm_div below it).
//
//  channel   handshake                 payload
//  -------   -----------------------   -------------------------------------------
//  command   start / busy              opcode, col, row, sample_value
//  result    result_valid (strobe)     kind, height_raw, normal_*, tex_*, index_*,
//                                      last, bad_coordinate
//  config    cfg_we                    cfg_index, cfg_data
//
// A command is a transfer when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Each result is valid for exactly
// one cycle; the receiver cannot stall, so the back end never waits on it.
// A vertex takes four passes of the shared divider (map steps and both texture
// coordinates) and seven reads of the single-port height store. Reset (async,
// active low) clears control and config; the height store is not cleared and
// must be loaded before use.
module terrain_grid_mesh_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [7:0]         col,
    input  logic [7:0]         row,
    input  logic [7:0]         sample_value,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output logic               result_valid,
    output logic               kind,
    output logic [7:0]         height_raw,
    output logic signed [11:0] normal_x,
    output logic [6:0]         normal_y,
    output logic signed [11:0] normal_z,
    output logic [17:0]        tex_u,
    output logic [17:0]        tex_v,
    output logic [15:0]        index_a,
    output logic [15:0]        index_b,
    output logic [15:0]        index_c,
    output logic               last,
    output logic               bad_coordinate
);
    import tgm_pkg::*;

    logic [CFG_W-1:0] gx_reg, gz_reg, mw_reg, mh_reg;
    logic             use_map_reg;
    cfg_t             cfg;
    logic             job_valid, job_take;
    job_t             job;
    result_t          res;

    // Register file; out-of-range indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg      <= 9'd2;
            gz_reg      <= 9'd2;
            mw_reg      <= 9'd1;
            mh_reg      <= 9'd1;
            use_map_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_X:  gx_reg      <= cfg_data;
                CFG_GRID_Z:  gz_reg      <= cfg_data;
                CFG_MAP_W:   mw_reg      <= cfg_data;
                CFG_MAP_H:   mh_reg      <= cfg_data;
                CFG_USE_MAP: use_map_reg <= cfg_data[0];
                default:     use_map_reg <= use_map_reg;
            endcase
        end
    end

    // Clamp to legal ranges: grid 2..MAX_GRID_SIDE, map 1..MAX_MAP_SIDE.
    assign cfg.gx = (gx_reg < 9'd2) ? 9'd2 :
                    (gx_reg > 9'(MAX_GRID_SIDE)) ? 9'(MAX_GRID_SIDE) : gx_reg;
    assign cfg.gz = (gz_reg < 9'd2) ? 9'd2 :
                    (gz_reg > 9'(MAX_GRID_SIDE)) ? 9'(MAX_GRID_SIDE) : gz_reg;
    assign cfg.mw = (mw_reg < 9'd1) ? 9'd1 :
                    (mw_reg > 9'(MAX_MAP_SIDE)) ? 9'(MAX_MAP_SIDE) : mw_reg;
    assign cfg.mh = (mh_reg < 9'd1) ? 9'd1 :
                    (mh_reg > 9'(MAX_MAP_SIDE)) ? 9'(MAX_MAP_SIDE) : mh_reg;
    assign cfg.use_map = use_map_reg;

    tgm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (start),
        .opcode       (opcode),
        .col          (col),
        .row          (row),
        .sample_value (sample_value),
        .busy         (busy),
        .job_valid    (job_valid),
        .job          (job),
        .job_take     (job_take)
    );

    tgm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .res_valid (result_valid),
        .res       (res)
    );

    assign kind           = res.kind;
    assign height_raw     = res.height_raw;
    assign normal_x       = res.normal_x;
    assign normal_y       = res.normal_y;
    assign normal_z       = res.normal_z;
    assign tex_u          = res.tex_u;
    assign tex_v          = res.tex_v;
    assign index_a        = res.index_a;
    assign index_b        = res.index_b;
    assign index_c        = res.index_c;
    assign last           = res.last;
    assign bad_coordinate = res.bad_coordinate;
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for terrain_grid_mesh_generator: height loads,
// vertices and cell triangles, checked against a behavioral mesh predictor.
// Depends on tgm_pkg (opcodes, register indexes, result_t).
module tb;
    import tgm_pkg::*;

    // Mesh predictor and store of pending results.
    class mesh_scoreboard;
        int unsigned gx_reg, gz_reg, mw_reg, mh_reg, use_reg;
        byte unsigned heights[STORE_DEPTH];
        result_t pending_results[$];
        int errors;

        function new();
            gx_reg = 2; gz_reg = 2; mw_reg = 1; mh_reg = 1; use_reg = 0;
            errors = 0;
        endfunction

        function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void set_reg(logic [2:0] idx, logic [8:0] val);
            case (idx)
                CFG_GRID_X:  gx_reg = val;
                CFG_GRID_Z:  gz_reg = val;
                CFG_MAP_W:   mw_reg = val;
                CFG_MAP_H:   mh_reg = val;
                CFG_USE_MAP: use_reg = val[0];
                default: ;
            endcase
        endfunction

        function int grid_height(int unsigned i, int unsigned j);
            int unsigned gx, gz, mw, mh, mx, my;
            gx = clampu(gx_reg, 2, MAX_GRID_SIDE);
            gz = clampu(gz_reg, 2, MAX_GRID_SIDE);
            mw = clampu(mw_reg, 1, MAX_MAP_SIDE);
            mh = clampu(mh_reg, 1, MAX_MAP_SIDE);
            if (use_reg == 0)
                return 0;
            my = (mh / (gz - 1)) * j;
            mx = (mw / (gx - 1)) * i;
            if (my > mh - 1) my = mh - 1;
            if (mx > mw - 1) mx = mw - 1;
            return heights[my * mw + mx];
        endfunction

        // Face normal of one of the two triangles of cell (ci, cj), if it exists.
        function void add_face(int ci, int cj, bit second, inout int nx, inout int ny,
                               inout int nz);
            int a, b, c, d, gx, gz;
            gx = clampu(gx_reg, 2, MAX_GRID_SIDE);
            gz = clampu(gz_reg, 2, MAX_GRID_SIDE);
            if (ci < 0 || cj < 0 || ci >= gx - 1 || cj >= gz - 1)
                return;
            a = grid_height(ci, cj + 1);
            c = grid_height(ci + 1, cj);
            if (!second) begin
                b = grid_height(ci + 1, cj + 1);
                nx += a - b;
                nz += c - b;
            end
            else begin
                d = grid_height(ci, cj);
                nx += d - c;
                nz += d - a;
            end
            ny += 15;
        endfunction

        // Called for every accepted command transfer.
        function void note_command(logic [1:0] op, int unsigned c, int unsigned r,
                                   logic [7:0] sample);
            result_t res;
            int nx, ny, nz, i, j;
            int unsigned gx, gz, mw, mh, v;
            longint unsigned one;
            gx = clampu(gx_reg, 2, MAX_GRID_SIDE);
            gz = clampu(gz_reg, 2, MAX_GRID_SIDE);
            mw = clampu(mw_reg, 1, MAX_MAP_SIDE);
            mh = clampu(mh_reg, 1, MAX_MAP_SIDE);
            one = longint'(1) << UV_FRACTION_BITS;
            res = '0;
            nx = 0; ny = 0; nz = 0;
            i = c; j = r;
            case (op)
                OP_LOAD:
                begin
                    if (c < mw && r < mh)
                        heights[r * mw + c] = sample;
                end
                OP_VERTEX:
                begin
                    res.last = 1'b1;
                    if (c >= gx || r >= gz)
                        res.bad_coordinate = 1'b1;
                    else begin
                        add_face(i, j, 1, nx, ny, nz);
                        add_face(i, j - 1, 0, nx, ny, nz);
                        add_face(i, j - 1, 1, nx, ny, nz);
                        add_face(i - 1, j - 1, 0, nx, ny, nz);
                        add_face(i - 1, j, 0, nx, ny, nz);
                        add_face(i - 1, j, 1, nx, ny, nz);
                        res.height_raw = 8'(grid_height(c, r));
                        res.normal_x = 12'(nx);
                        res.normal_y = 7'(ny);
                        res.normal_z = 12'(nz);
                        res.tex_u = 18'((TEX_REPEAT * c * one) / (gx - 1));
                        res.tex_v = 18'((TEX_REPEAT * (gz - 1 - r) * one) / (gz - 1));
                    end
                    pending_results.push_back(res);
                end
                OP_CELL:
                begin
                    res.kind = 1'b1;
                    if (c >= gx - 1 || r >= gz - 1) begin
                        res.last = 1'b1;
                        res.bad_coordinate = 1'b1;
                        pending_results.push_back(res);
                    end
                    else begin
                        v = r * gx + c;
                        res.index_a = 16'(v + gx);
                        res.index_b = 16'(v + gx + 1);
                        res.index_c = 16'(v + 1);
                        pending_results.push_back(res);
                        res.index_b = 16'(v + 1);
                        res.index_c = 16'(v);
                        res.last = 1'b1;
                        pending_results.push_back(res);
                    end
                end
                default: ;  // opcode 3 is ignored
            endcase
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind %0d want %0d", got.kind, want.kind));
            if (got.height_raw != want.height_raw)
                report($sformatf("height_raw %0d want %0d", got.height_raw, want.height_raw));
            if (got.normal_x != want.normal_x)
                report($sformatf("normal_x %0d want %0d", got.normal_x, want.normal_x));
            if (got.normal_y != want.normal_y)
                report($sformatf("normal_y %0d want %0d", got.normal_y, want.normal_y));
            if (got.normal_z != want.normal_z)
                report($sformatf("normal_z %0d want %0d", got.normal_z, want.normal_z));
            if (got.tex_u != want.tex_u)
                report($sformatf("tex_u %0d want %0d", got.tex_u, want.tex_u));
            if (got.tex_v != want.tex_v)
                report($sformatf("tex_v %0d want %0d", got.tex_v, want.tex_v));
            if (got.index_a != want.index_a)
                report($sformatf("index_a %0d want %0d", got.index_a, want.index_a));
            if (got.index_b != want.index_b)
                report($sformatf("index_b %0d want %0d", got.index_b, want.index_b));
            if (got.index_c != want.index_c)
                report($sformatf("index_c %0d want %0d", got.index_c, want.index_c));
            if (got.last != want.last)
                report($sformatf("last %0d want %0d", got.last, want.last));
            if (got.bad_coordinate != want.bad_coordinate)
                report($sformatf("bad_coordinate %0d want %0d", got.bad_coordinate,
                                 want.bad_coordinate));
        endtask
    endclass

    localparam int STALL_LIMIT = 5000;   // cycles without any transfer
    localparam int SETTLE = 200;         // covers a vertex plus queued loads

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         opcode = OP_LOAD;
    logic [7:0]         col = '0;
    logic [7:0]         row = '0;
    logic [7:0]         sample_value = '0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = CFG_GRID_X;
    logic [8:0]         cfg_data = '0;
    logic               result_valid;
    result_t            res_bus;
    int                 stall_cycles = 0;
    bit                 idling_on = 1'b1;
    mesh_scoreboard     sb;

    terrain_grid_mesh_generator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .col            (col),
        .row            (row),
        .sample_value   (sample_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .kind           (res_bus.kind),
        .height_raw     (res_bus.height_raw),
        .normal_x       (res_bus.normal_x),
        .normal_y       (res_bus.normal_y),
        .normal_z       (res_bus.normal_z),
        .tex_u          (res_bus.tex_u),
        .tex_v          (res_bus.tex_v),
        .index_a        (res_bus.index_a),
        .index_b        (res_bus.index_b),
        .index_c        (res_bus.index_c),
        .last           (res_bus.last),
        .bad_coordinate (res_bus.bad_coordinate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result monitor: every strobe is a transfer, checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(res_bus);
    end

    // Watchdog: any command or result transfer restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // One command transfer; start stays high into the next call when there is no gap.
    task send_command(logic [1:0] op, logic [7:0] c, logic [7:0] r, logic [7:0] s);
        start <= 1'b1;
        opcode <= op;
        col <= c;
        row <= r;
        sample_value <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(op, c, r, s);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Drop start and wait until every expected result is in, then let loads finish.
    task drain;
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_reg(logic [2:0] idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Raw register values; the block clamps them as the predictor does.
    task set_mesh(int gx, int gz, int mw, int mh, bit use_map);
        drain();
        write_reg(CFG_GRID_X, 9'(gx));
        write_reg(CFG_GRID_Z, 9'(gz));
        write_reg(CFG_MAP_W, 9'(mw));
        write_reg(CFG_MAP_H, 9'(mh));
        write_reg(CFG_USE_MAP, 9'(use_map));
        @(posedge clk);
    endtask

    // Writes every map sample, so no vertex ever reads an unwritten entry.
    task fill_map(int mw, int mh);
        for (int y = 0; y < mh; y++)
            for (int x = 0; x < mw; x++)
                send_command(OP_LOAD, 8'(x), 8'(y), 8'($urandom_range(0, 255)));
    endtask

    function logic [7:0] pick_coord(int unsigned side);
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, side < 256 ? side : 255));
    endfunction

    // Random mix; coordinates mostly near the grid, some anywhere.
    task random_commands(int count, int unsigned gx, int unsigned gz,
                         int unsigned mw, int unsigned mh);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_command(OP_LOAD, pick_coord(mw), pick_coord(mh),
                             8'($urandom_range(0, 255)));
            else if (pick < 15)
                send_command(2'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            else if (pick < 65)
                send_command(OP_VERTEX, pick_coord(gx), pick_coord(gz),
                             8'($urandom_range(0, 255)));
            else
                send_command(OP_CELL, pick_coord(gx), pick_coord(gz),
                             8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 2x2 grid, flat.
        send_command(OP_VERTEX, 0, 0, 8'hFF);
        send_command(OP_VERTEX, 1, 1, 0);
        send_command(OP_CELL, 0, 0, 0);
        send_command(OP_CELL, 1, 0, 0);

        // Small mapped grid: corners, edges, interior, bad coordinates.
        set_mesh(4, 3, 8, 5, 1);
        fill_map(8, 5);
        send_command(OP_LOAD, 2, 0, 8'hFF);     // sampled by vertex (1,0)
        send_command(OP_LOAD, 4, 2, 8'h00);
        send_command(OP_LOAD, 8, 0, 8'h55);     // outside the map: ignored
        send_command(OP_LOAD, 0, 5, 8'hAA);     // outside the map: ignored
        send_command(2'd3, 8'hFF, 8'hFF, 8'hFF);
        send_command(OP_VERTEX, 0, 0, 0);
        send_command(OP_VERTEX, 1, 0, 0);
        send_command(OP_VERTEX, 3, 2, 0);
        send_command(OP_VERTEX, 2, 1, 0);
        send_command(OP_VERTEX, 3, 0, 0);
        send_command(OP_VERTEX, 0, 2, 0);
        send_command(OP_VERTEX, 4, 0, 0);
        send_command(OP_VERTEX, 0, 3, 0);
        send_command(OP_VERTEX, 8'hFF, 8'hFF, 0);
        send_command(OP_CELL, 0, 0, 0);
        send_command(OP_CELL, 2, 1, 0);
        send_command(OP_CELL, 3, 0, 0);
        send_command(OP_CELL, 0, 2, 0);
        random_commands(50, 4, 3, 8, 5);

        // Largest grid and map, flat, so the full coordinate range is in use.
        set_mesh(256, 256, 256, 256, 0);
        send_command(OP_VERTEX, 255, 255, 0);
        send_command(OP_VERTEX, 255, 0, 0);
        send_command(OP_CELL, 254, 254, 0);
        send_command(OP_CELL, 255, 254, 0);
        random_commands(50, 256, 256, 256, 256);

        // Smallest map, mapped.
        set_mesh(2, 2, 1, 1, 1);
        fill_map(1, 1);
        random_commands(40, 2, 2, 1, 1);

        // Wide single-row map across a full-width grid.
        set_mesh(256, 2, 256, 1, 1);
        fill_map(256, 1);
        random_commands(45, 256, 2, 256, 1);

        // Out-of-range register values are clamped.
        set_mesh(0, 511, 0, 511, 0);
        random_commands(45, 2, 256, 1, 256);

        set_mesh(17, 9, 8, 8, 1);
        fill_map(8, 8);
        random_commands(55, 17, 9, 8, 8);

        // Last stretch: back to back, no idling.
        set_mesh(5, 7, 3, 2, 1);
        idling_on = 1'b0;
        fill_map(3, 2);
        random_commands(55, 5, 7, 3, 2);

        drain();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
